// ===== hdl/asc_pkg.sv =====
// shared types and constants for the activity step counter
`timescale 1ns / 1ps

package asc_pkg;

    localparam int unsigned AXIS_W         = 16;
    localparam int unsigned LEVEL_W        = 16;
    localparam int unsigned TIME_W         = 32;
    localparam int unsigned TOTAL_W        = 32;
    localparam int unsigned SUM_W          = 32;
    localparam int unsigned CFG_INDEX_W    = 3;
    localparam int unsigned COUNT_BITS_DEF = 32;

    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned ROOT_STEPS = SUM_W / 2;
    localparam int unsigned STEP_CNT_W = $clog2(ROOT_STEPS);

    // first trial bit of the restoring root: highest even power of two in the sum
    localparam logic [SUM_W-1:0] ROOT_FIRST_BIT = SUM_W'(1) << (SUM_W - 2);

    // reset levels of the config registers
    localparam logic [LEVEL_W-1:0] ONE_G_RESET     = LEVEL_W'(16384);
    localparam logic [LEVEL_W-1:0] STILL_RESET     = LEVEL_W'(820);
    localparam logic [LEVEL_W-1:0] WALK_RESET      = LEVEL_W'(4096);
    localparam logic [LEVEL_W-1:0] RISE_RESET      = LEVEL_W'(2457);
    localparam logic [LEVEL_W-1:0] FALL_RESET      = LEVEL_W'(1229);
    localparam logic [LEVEL_W-1:0] MIN_GAP_RESET   = LEVEL_W'(200);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ONE_G   = 3'd0,
        REG_STILL   = 3'd1,
        REG_WALK    = 3'd2,
        REG_RISE    = 3'd3,
        REG_FALL    = 3'd4,
        REG_MIN_GAP = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_STILL = 2'd0,
        ACT_WALK  = 2'd1,
        ACT_RUN   = 2'd2
    } activity_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] one_g_level;
        logic [LEVEL_W-1:0] still_limit;
        logic [LEVEL_W-1:0] walk_limit;
        logic [LEVEL_W-1:0] step_rise_level;
        logic [LEVEL_W-1:0] step_fall_level;
        logic [LEVEL_W-1:0] min_step_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic  load;
        logic  square;
        axis_t axis;
        logic  root_step;
        logic  finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/accel_activity_step_counter_core.sv =====
// top level of the accelerometer activity classifier and step counter
`timescale 1ns / 1ps

// Takes one three-axis sample with its millisecond stamp per word and returns one
// result word: magnitude (floor root of the summed squares), motion away from one g,
// activity class, whether this sample counted a step, and the running step total.
// The accepting edge captures the sample; its result is then built by one squaring
// per axis through the single shared 16x16 squarer, sixteen iterations of the
// bit-at-a-time restoring root, and a finish step for the motion, class and step
// decision, which writes the output register. in_ready is high only while the
// sequencer is idle, so a new sample waits for the last one's finish step; a result
// waiting in the output register does not block the next sample, only its finish step.
// Config registers may be written at any time the block holds no sample.

module accel_activity_step_counter_core
    import asc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [LEVEL_W-1:0]       cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [AXIS_W-1:0] accel_x,
    input  logic signed [AXIS_W-1:0] accel_y,
    input  logic signed [AXIS_W-1:0] accel_z,
    input  logic [TIME_W-1:0]        time_ms,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [LEVEL_W-1:0]       magnitude,
    output logic [LEVEL_W-1:0]       motion,
    output logic [1:0]               activity,
    output logic                     step_counted,
    output logic [TOTAL_W-1:0]       step_total
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    asc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    asc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    asc_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .magnitude    (magnitude),
        .motion       (motion),
        .activity     (activity),
        .step_counted (step_counted),
        .step_total   (step_total)
    );

endmodule

// ===== hdl/asc_cfg_regs.sv =====
// configuration register file for the activity step counter
`timescale 1ns / 1ps

module asc_cfg_regs
    import asc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]     cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_ONE_G:   cfg_next.one_g_level     = cfg_data;
                REG_STILL:   cfg_next.still_limit     = cfg_data;
                REG_WALK:    cfg_next.walk_limit      = cfg_data;
                REG_RISE:    cfg_next.step_rise_level = cfg_data;
                REG_FALL:    cfg_next.step_fall_level = cfg_data;
                REG_MIN_GAP: cfg_next.min_step_gap_ms = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_g_level     <= ONE_G_RESET;
            cfg_reg.still_limit     <= STILL_RESET;
            cfg_reg.walk_limit      <= WALK_RESET;
            cfg_reg.step_rise_level <= RISE_RESET;
            cfg_reg.step_fall_level <= FALL_RESET;
            cfg_reg.min_step_gap_ms <= MIN_GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/asc_ctrl.sv =====
// sequencer: capture, squaring of each axis, root iterations, result write
`timescale 1ns / 1ps

module asc_ctrl
    import asc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t                state_reg;
    state_t                state_next;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [STEP_CNT_W-1:0] cnt_next;

    localparam logic [STEP_CNT_W-1:0] LAST_AXIS = STEP_CNT_W'(NUM_AXES - 1);
    localparam logic [STEP_CNT_W-1:0] LAST_ROOT = STEP_CNT_W'(ROOT_STEPS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.square    = 1'b0;
        cmd.axis      = AXIS_X;
        cmd.root_step = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                case (cnt_reg[1:0])
                    2'd0:    cmd.axis = AXIS_X;
                    2'd1:    cmd.axis = AXIS_Y;
                    default: cmd.axis = AXIS_Z;
                endcase
                if (cnt_reg == LAST_AXIS)
                begin
                    cnt_next   = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == LAST_ROOT)
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register can take the word
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("result written while output word still pending");

    a_accept_starts_square: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SQUARE) && (cnt_reg == '0))
        else $error("accepted sample did not start squaring");

    a_root_ends_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && cnt_reg == LAST_ROOT) |=> (state_reg == ST_FINISH))
        else $error("root iterations did not end in finish");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.square, cmd.root_step, cmd.finish}))
        else $error("more than one datapath command at once");

endmodule

// ===== hdl/asc_datapath.sv =====
// datapath: axis magnitudes, shared squarer, restoring root, step detector, output word
`timescale 1ns / 1ps

module asc_datapath
    import asc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic signed [AXIS_W-1:0]   accel_x,
    input  logic signed [AXIS_W-1:0]   accel_y,
    input  logic signed [AXIS_W-1:0]   accel_z,
    input  logic [TIME_W-1:0]          time_ms,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [LEVEL_W-1:0]         magnitude,
    output logic [LEVEL_W-1:0]         motion,
    output logic [1:0]                 activity,
    output logic                       step_counted,
    output logic [TOTAL_W-1:0]         step_total
);

    // captured sample
    logic [AXIS_W-1:0] abs_x_reg;
    logic [AXIS_W-1:0] abs_y_reg;
    logic [AXIS_W-1:0] abs_z_reg;
    logic [TIME_W-1:0] now_reg;

    // root working set; squares accumulate straight into the remainder
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] rem_next;
    logic [SUM_W-1:0] root_reg;
    logic [SUM_W-1:0] root_next;
    logic [SUM_W-1:0] bit_reg;
    logic [SUM_W-1:0] bit_next;

    // detector state
    logic [TIME_W-1:0]     last_stamp_reg;
    logic [TIME_W-1:0]     last_stamp_next;
    logic [COUNT_BITS-1:0] tally_reg;
    logic [COUNT_BITS-1:0] tally_next;
    logic                  armed_high_reg;
    logic                  armed_high_next;

    // output word
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [LEVEL_W-1:0] magnitude_reg;
    logic [LEVEL_W-1:0] motion_reg;
    activity_t          activity_reg;
    logic               counted_reg;

    logic [AXIS_W-1:0]  sel_abs;
    logic [SUM_W-1:0]   square;
    logic [SUM_W-1:0]   trial;
    logic [LEVEL_W-1:0] mag;
    logic [LEVEL_W-1:0] mot;
    activity_t          act;
    logic               edge_hit;
    logic               gap_ok;
    logic [TIME_W-1:0]  elapsed;

    function automatic logic [AXIS_W-1:0] abs_axis(input logic signed [AXIS_W-1:0] v);
        // most negative value maps to its magnitude as an unsigned word
        return v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
    endfunction

    always_comb
    begin
        case (cmd.axis)
            AXIS_X:  sel_abs = abs_x_reg;
            AXIS_Y:  sel_abs = abs_y_reg;
            default: sel_abs = abs_z_reg;
        endcase
    end

    assign square = {{(SUM_W-AXIS_W){1'b0}}, sel_abs} * {{(SUM_W-AXIS_W){1'b0}}, sel_abs};
    assign trial  = root_reg + bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (cmd.load)
        begin
            rem_next  = '0;
            root_next = '0;
            bit_next  = ROOT_FIRST_BIT;
        end
        else if (cmd.square)
        begin
            rem_next = rem_reg + square;
        end
        else if (cmd.root_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    // finish cycle: motion, class and step decision
    assign mag     = root_reg[LEVEL_W-1:0];
    assign mot     = (mag >= cfg.one_g_level) ? (mag - cfg.one_g_level)
                                              : (cfg.one_g_level - mag);
    assign elapsed = now_reg - last_stamp_reg;
    assign gap_ok  = elapsed > {{(TIME_W-LEVEL_W){1'b0}}, cfg.min_step_gap_ms};
    assign edge_hit = (mot > cfg.step_rise_level) && !armed_high_reg;

    always_comb
    begin
        if (mot < cfg.still_limit)
            act = ACT_STILL;
        else if (mot < cfg.walk_limit)
            act = ACT_WALK;
        else
            act = ACT_RUN;
    end

    always_comb
    begin
        last_stamp_next = last_stamp_reg;
        tally_next      = tally_reg;
        armed_high_next = armed_high_reg;
        if (cmd.finish)
        begin
            if (edge_hit)
            begin
                if (gap_ok)
                begin
                    tally_next      = tally_reg + 1'b1;
                    last_stamp_next = now_reg;
                end
                armed_high_next = 1'b1;
            end
            // fall test runs after the edge, so both can apply in one sample
            if (mot < cfg.step_fall_level)
                armed_high_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.finish)
            out_valid_next = 1'b1;
    end

    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
            tally_reg      <= '0;
            armed_high_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            last_stamp_reg <= last_stamp_next;
            tally_reg      <= tally_next;
            armed_high_reg <= armed_high_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            abs_x_reg <= abs_axis(accel_x);
            abs_y_reg <= abs_axis(accel_y);
            abs_z_reg <= abs_axis(accel_z);
            now_reg   <= time_ms;
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        if (cmd.finish)
        begin
            magnitude_reg <= mag;
            motion_reg    <= mot;
            activity_reg  <= act;
            counted_reg   <= edge_hit && gap_ok;
        end
    end

    assign out_valid    = out_valid_reg;
    assign magnitude    = magnitude_reg;
    assign motion       = motion_reg;
    assign activity     = activity_reg;
    assign step_counted = counted_reg;
    assign step_total   = TOTAL_W'(tally_reg);

    a_root_done_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (bit_reg == '0))
        else $error("finish before the root iterations ran out");

    a_count_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (tally_reg != $past(tally_reg)) |-> $past(cmd.finish))
        else $error("step tally moved outside a finish cycle");

    a_counted_moves_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && edge_hit && gap_ok) |=> (last_stamp_reg == $past(now_reg)))
        else $error("counted step did not record its timestamp");

endmodule

// ===== tb/sv/tb_accel_activity_step_counter_core.sv =====
// self-checking testbench for the activity step counter core
`timescale 1ns / 1ps

import asc_pkg::*;

typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    logic [TIME_W-1:0]        stamp;
} sample_t;

typedef struct packed {
    logic [LEVEL_W-1:0] magnitude;
    logic [LEVEL_W-1:0] motion;
    logic [1:0]         activity;
    logic               step_counted;
    logic [TOTAL_W-1:0] step_total;
} step_report_t;

class step_checker;
    cfg_t               levels;
    logic [TIME_W-1:0]  last_stamp;
    logic [TOTAL_W-1:0] tally;
    bit                 disarmed;
    step_report_t       due_reports[$];
    int                 failures;

    function new();
        levels = '{ONE_G_RESET, STILL_RESET, WALK_RESET, RISE_RESET, FALL_RESET,
                   MIN_GAP_RESET};
        last_stamp = '0;
        tally      = '0;
        disarmed   = 1'b0;
        failures   = 0;
    endfunction

    function void set_level(logic [CFG_INDEX_W-1:0] idx, logic [LEVEL_W-1:0] val);
        case (idx)
            REG_ONE_G:   levels.one_g_level     = val;
            REG_STILL:   levels.still_limit     = val;
            REG_WALK:    levels.walk_limit      = val;
            REG_RISE:    levels.step_rise_level = val;
            REG_FALL:    levels.step_fall_level = val;
            REG_MIN_GAP: levels.min_step_gap_ms = val;
            default:     ;
        endcase
    endfunction

    // binary search for the largest root whose square fits
    function logic [LEVEL_W-1:0] floor_root(logic [SUM_W-1:0] n);
        logic [LEVEL_W-1:0] root;
        logic [LEVEL_W-1:0] trial;
        root = '0;
        for (int b = LEVEL_W - 1; b >= 0; b--)
        begin
            trial = root | (16'd1 << b);
            if ({16'd0, trial} * {16'd0, trial} <= n)
                root = trial;
        end
        return root;
    endfunction

    function void note_sample(sample_t s);
        longint             vx;
        longint             vy;
        longint             vz;
        logic [SUM_W-1:0]   energy;
        logic [LEVEL_W-1:0] root;
        logic [LEVEL_W-1:0] away;
        logic [TIME_W-1:0]  elapsed;
        step_report_t       r;
        vx = $signed(s.x);
        vy = $signed(s.y);
        vz = $signed(s.z);
        if (vx < 0)
            vx = -vx;
        if (vy < 0)
            vy = -vy;
        if (vz < 0)
            vz = -vz;
        energy = SUM_W'(vx * vx + vy * vy + vz * vz);
        root = floor_root(energy);
        if (root >= levels.one_g_level)
            away = root - levels.one_g_level;
        else
            away = levels.one_g_level - root;
        r.magnitude = root;
        r.motion    = away;
        if (away < levels.still_limit)
            r.activity = ACT_STILL;
        else if (away < levels.walk_limit)
            r.activity = ACT_WALK;
        else
            r.activity = ACT_RUN;
        r.step_counted = 1'b0;
        // an edge disarms even when it comes too soon to count
        if (away > levels.step_rise_level && !disarmed)
        begin
            elapsed = s.stamp - last_stamp;
            if (elapsed > TIME_W'(levels.min_step_gap_ms))
            begin
                tally = tally + 1'b1;
                last_stamp = s.stamp;
                r.step_counted = 1'b1;
            end
            disarmed = 1'b1;
        end
        if (away < levels.step_fall_level)
            disarmed = 1'b0;
        r.step_total = tally;
        due_reports.push_back(r);
    endfunction

    function void compare(string what, logic [63:0] want, logic [63:0] seen);
        if (want !== seen)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what,
                     want, seen);
        end
    endfunction

    function void check_report(step_report_t seen);
        step_report_t want;
        if (due_reports.size() == 0)
        begin
            failures++;
            $display("%0t: result word with nothing expected, actual magnitude %0d",
                     $time, seen.magnitude);
            return;
        end
        want = due_reports.pop_front();
        compare("magnitude", want.magnitude, seen.magnitude);
        compare("motion", want.motion, seen.motion);
        compare("activity", want.activity, seen.activity);
        compare("step_counted", want.step_counted, seen.step_counted);
        compare("step_total", want.step_total, seen.step_total);
    endfunction

    function int pending();
        return due_reports.size();
    endfunction

    function void close_out();
        if (due_reports.size() != 0)
        begin
            failures += due_reports.size();
            $display("%0t: %0d expected words never arrived, expected 0, actual %0d",
                     $time, due_reports.size(), due_reports.size());
        end
    endfunction
endclass

module tb_accel_activity_step_counter_core;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PHASE_ITEMS   = 66;
    localparam int NUM_PHASES    = 6;
    localparam int CALM_FROM     = 340;
    localparam int HOLD_AT_WORD  = 50;
    localparam int HOLD_CYCLES   = 150;

    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

    localparam int DRILL_LEN = 26;
    localparam sample_t DRILL [DRILL_LEN] = '{
        '{16'sd0, 16'sd0, 16'sd0, 32'd0},                  // edge before the gap has passed
        '{16'sd0, 16'sd0, 16'sd16384, 32'd5},
        '{16'sd32767, 16'sd32767, 16'sd32767, 32'd1000},
        '{16'h8000, 16'h8000, 16'h8000, 32'd1100},
        '{16'sd16384, 16'sd0, 16'sd0, 32'd1150},
        '{16'sd0, -16'sd20000, 16'sd0, 32'd1200},          // gap exactly the minimum
        '{16'sd0, 16'sd0, -16'sd16384, 32'd1210},
        '{16'sd0, 16'sd0, 16'sd18842, 32'd1201},           // one past the rise level
        '{16'sd0, 16'sd0, 16'sd16384, 32'd1250},
        '{16'sd0, 16'sd0, 16'sd18841, 32'd2000},           // at the rise level
        '{16'sd0, 16'sd0, 16'sd30000, 32'd2020},
        '{16'sd0, 16'sd0, 16'sd17613, 32'd2030},           // at the fall level, stays high
        '{16'sd0, 16'sd0, 16'sd17612, 32'd2510},
        '{16'sd0, 16'sd0, 16'sd17204, 32'd2520},
        '{16'sd0, 16'sd0, 16'sd17203, 32'd2530},
        '{16'sd0, 16'sd0, 16'sd20480, 32'd2540},
        '{16'sd0, 16'sd0, 16'sd20479, 32'd2550},
        '{16'sd0, 16'sd0, 16'sd12288, 32'd2560},           // below one g
        '{16'sd0, 16'sd0, 16'sd16384, 32'hFFFF_FF00},
        '{16'sd0, 16'sd0, 16'sd30000, 32'hFFFF_FF10},
        '{16'sd0, 16'sd0, 16'sd16384, 32'hFFFF_FF20},
        '{16'sd0, 16'sd0, 16'sd30000, 32'h0000_0020},      // stamp wrapped
        '{16'sd0, 16'sd0, 16'sd16384, 32'h0000_0030},
        '{16'sd0, 16'sd0, 16'sd30000, 32'h0000_0010},      // stamp went backward
        '{16'hFFFF, 16'sd1, 16'hFFFF, 32'hFFFF_FFFF},
        '{16'h8000, 16'sd0, 16'sd0, 32'd12345}
    };

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [LEVEL_W-1:0]       cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic [TIME_W-1:0]        time_ms;
    logic                     out_valid;
    logic                     out_ready;
    logic [LEVEL_W-1:0]       magnitude;
    logic [LEVEL_W-1:0]       motion;
    logic [1:0]               activity;
    logic                     step_counted;
    logic [TOTAL_W-1:0]       step_total;

    step_checker       tracker = new();
    cfg_t              levels;
    logic [TIME_W-1:0] clock_ms;
    bit                stride_high;
    bit                calm_tail;
    int                cycle_count;

    accel_activity_step_counter_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .magnitude    (magnitude),
        .motion       (motion),
        .activity     (activity),
        .step_counted (step_counted),
        .step_total   (step_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [AXIS_W-1:0] extreme_axis();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly walking-like strides around one g, some raw noise, some extremes
    function automatic sample_t next_sample();
        sample_t                  s;
        int                       pick;
        int                       spread;
        int                       target;
        int                       share;
        logic signed [AXIS_W-1:0] lead;
        logic signed [AXIS_W-1:0] side_a;
        logic signed [AXIS_W-1:0] side_b;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            if ($urandom_range(0, 9) < 7)
                stride_high = !stride_high;
            if (stride_high)
                spread = int'(levels.step_rise_level) + $urandom_range(0, 6000);
            else
                spread = $urandom_range(0, int'(levels.step_fall_level) + 20);
            if ($urandom_range(0, 1) != 0)
                target = int'(levels.one_g_level) + spread;
            else
                target = int'(levels.one_g_level) - spread;
            if (target < 0)
                target = -target;
            if (target > 56000)
                target = 56000;
            if (target <= 32767)
            begin
                lead   = 16'(target);
                side_a = 16'($urandom_range(0, 128)) - 16'sd64;
                side_b = 16'($urandom_range(0, 128)) - 16'sd64;
            end
            else
            begin
                // spread a large magnitude over all three axes
                share  = target * 577 / 1000;
                lead   = 16'(share);
                side_a = ($urandom_range(0, 1) != 0) ? 16'(share) : -16'(share);
                side_b = ($urandom_range(0, 1) != 0) ? 16'(share) : -16'(share);
            end
            if ($urandom_range(0, 1) != 0)
                lead = -lead;
            case ($urandom_range(0, 2))
                0:
                begin
                    s.x = lead;
                    s.y = side_a;
                    s.z = side_b;
                end
                1:
                begin
                    s.x = side_a;
                    s.y = lead;
                    s.z = side_b;
                end
                default:
                begin
                    s.x = side_a;
                    s.y = side_b;
                    s.z = lead;
                end
            endcase
            clock_ms = clock_ms + $urandom_range(0, 2 * int'(levels.min_step_gap_ms) + 60);
        end
        else if (pick < 85)
        begin
            s.x = 16'($urandom);
            s.y = 16'($urandom);
            s.z = 16'($urandom);
            clock_ms = clock_ms + $urandom_range(0, 1000);
        end
        else
        begin
            s.x = extreme_axis();
            s.y = extreme_axis();
            s.z = extreme_axis();
            if ($urandom_range(0, 1) != 0)
                clock_ms = $urandom;
            else
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
        end
        s.stamp = clock_ms;
        return s;
    endfunction

    function automatic cfg_t phase_levels(int phase);
        cfg_t c;
        case (phase)
            0: c = '{ONE_G_RESET, STILL_RESET, WALK_RESET, RISE_RESET, FALL_RESET,
                     MIN_GAP_RESET};
            1: c = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            // rise below fall and walk below still
            3: c = '{16'd16384, 16'd3000, 16'd1500, 16'd800, 16'd2500, 16'd50};
            4:
            begin
                c.one_g_level     = 16'($urandom_range(4096, 24000));
                c.still_limit     = 16'($urandom_range(0, 2000));
                c.walk_limit      = c.still_limit + 16'($urandom_range(0, 6000));
                c.step_rise_level = 16'($urandom_range(300, 5000));
                c.step_fall_level = 16'($urandom_range(0, int'(c.step_rise_level)));
                c.min_step_gap_ms = 16'($urandom_range(0, 500));
            end
            default:
            begin
                c = cfg_t'({$urandom, $urandom, $urandom});
                if (c.one_g_level == '0)
                    c.one_g_level = 16'd1;
            end
        endcase
        return c;
    endfunction

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.set_level(idx, val);
    endtask

    task automatic load_levels(input cfg_t c);
        put_reg(REG_ONE_G, c.one_g_level);
        put_reg(REG_STILL, c.still_limit);
        put_reg(REG_WALK, c.walk_limit);
        put_reg(REG_RISE, c.step_rise_level);
        put_reg(REG_FALL, c.step_fall_level);
        put_reg(REG_MIN_GAP, c.min_step_gap_ms);
        // unused indexes must leave every level alone
        put_reg(SPARE_INDEX_LO, 16'($urandom));
        put_reg(SPARE_INDEX_HI, 16'($urandom));
        cfg_write <= 1'b0;
        levels = c;
    endtask

    task automatic send_sample(input sample_t s);
        if (!calm_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        accel_x  <= s.x;
        accel_y  <= s.y;
        accel_z  <= s.z;
        time_ms  <= s.stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_sample(s);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            tracker.check_report('{magnitude, motion, activity, step_counted, step_total});
    end

    // receiver: short random stalls, one long hold-off so the input side backs up
    initial
    begin
        int words_taken;
        int pause_left;
        int go_left;
        bit held;
        words_taken = 0;
        pause_left  = 0;
        go_left     = 0;
        held        = 1'b0;
        out_ready   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
                words_taken++;
            if (!held && words_taken == HOLD_AT_WORD)
            begin
                held = 1'b1;
                pause_left = HOLD_CYCLES;
                go_left = 0;
            end
            if (pause_left == 0 && go_left == 0 && !calm_tail)
            begin
                if ($urandom_range(0, 2) == 0)
                    pause_left = $urandom_range(1, 6);
                else
                    go_left = $urandom_range(1, 12);
            end
            if (pause_left > 0)
            begin
                out_ready <= 1'b0;
                pause_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (go_left > 0)
                    go_left--;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int sent;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        accel_x     = '0;
        accel_y     = '0;
        accel_z     = '0;
        time_ms     = '0;
        clock_ms    = '0;
        stride_high = 1'b0;
        calm_tail   = 1'b0;
        levels      = phase_levels(0);
        sent        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed words run on the reset levels
        for (int i = 0; i < DRILL_LEN; i++)
            send_sample(DRILL[i]);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            load_levels(phase_levels(phase));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (sent >= CALM_FROM)
                    calm_tail = 1'b1;
                send_sample(next_sample());
                sent++;
            end
        end

        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.close_out();
        if (tracker.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
